// File: sv/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// shared types and constants for the three-led blink and pwm controller
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int MILLIS_W = 32;
  localparam int TIMING_W = 32;
  localparam int HALF_W   = 16;
  localparam int PERIOD_W = HALF_W + 1;
  localparam int CNT_W    = $clog2(MILLIS_W);
  localparam int NUM_LEDS = 3;

  localparam logic [PERIOD_W-1:0] SCROLL_CYCLE_MS = PERIOD_W'(750);
  localparam logic [PERIOD_W-1:0] SCROLL_STEP_MS  = PERIOD_W'(250);
  localparam logic [3:0]          TENTHS_PER_MS   = 4'd10;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DUTY   = 3'd0,
    REG_SCROLL = 3'd1,
    REG_INIT   = 3'd2,
    REG_LED0   = 3'd3,
    REG_LED1   = 3'd4,
    REG_LED2   = 3'd5
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // control from the sequencer to each remainder lane
  typedef struct packed {
    logic clear;
    logic step;
    logic din;
  } lane_ctl_t;

  // blink period: on + off, or twice on when off is zero
  function automatic logic [PERIOD_W-1:0] period_of(input logic [TIMING_W-1:0] timing);
    logic [HALF_W-1:0] on_ms;
    logic [HALF_W-1:0] off_ms;
    on_ms  = timing[HALF_W-1:0];
    off_ms = timing[TIMING_W-1:HALF_W];
    if (off_ms == '0) begin
      period_of = {on_ms, 1'b0};
    end else begin
      period_of = {1'b0, on_ms} + {1'b0, off_ms};
    end
  endfunction

endpackage

// File: sv/three_led_blink_pwm_controller_top.sv
// ----------------------------------------------------------------------------
// three_led_blink_pwm_controller_top
// 100 us tick driven pwm of three led pins with per-led blink timing
// ----------------------------------------------------------------------------
// output: the pin levels of a tick are registered at its transfer and appear in the cycle after it
// throughput: 1 tick per cycle while the pin channel is not stalled, except that
//   the tick that ends a millisecond in three-led mode holds off further ticks while
//   the 32-bit millisecond count is shifted msb first through three bit-serial remainder lanes
// reset: tenths, millis and led states clear, registers take their defaults
// ----------------------------------------------------------------------------
module three_led_blink_pwm_controller_top import lbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // tick channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                tick,
  // pin channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                pin0,
  output logic                pin1,
  output logic                pin2,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [TIMING_W-1:0] cfg_data
);

  // configuration registers
  logic [7:0]          duty_tenths;
  logic                scroll_enable;
  logic                initialised;
  logic [TIMING_W-1:0] led_timing [NUM_LEDS];

  // time base and led state
  logic [3:0]          tenths;
  logic [MILLIS_W-1:0] millis;
  logic [NUM_LEDS-1:0] led_on;

  // sequencer
  state_t              state;
  logic [CNT_W-1:0]    bit_cnt;
  logic [MILLIS_W-1:0] millis_sr;

  // per-tick logic
  logic                in_xfer;
  logic [3:0]          tenths_inc;
  logic                pwm;
  logic                ms_wrap;
  logic [MILLIS_W-1:0] millis_inc;

  // lanes
  lane_ctl_t           lane_ctl;
  logic [PERIOD_W-1:0] lane_div [NUM_LEDS];
  logic [PERIOD_W-1:0] lane_rem [NUM_LEDS];
  logic [NUM_LEDS-1:0] led_on_next;

  // writes held off while a recompute runs, the lanes read the timings
  assign cfg_ready = (state == ST_IDLE);

  // configuration writes; only done while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_tenths   <= 8'd5;
      scroll_enable <= 1'b0;
      initialised   <= 1'b0;
      for (int k = 0; k < NUM_LEDS; k++) begin
        led_timing[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DUTY:   duty_tenths   <= cfg_data[7:0];
        REG_SCROLL: scroll_enable <= cfg_data[0];
        REG_INIT:   initialised   <= cfg_data[0];
        REG_LED0:   led_timing[0] <= cfg_data;
        REG_LED1:   led_timing[1] <= cfg_data;
        REG_LED2:   led_timing[2] <= cfg_data;
        default:    ;
      endcase
    end
  end

  // a new tick is taken when the sequencer is idle and the pin register frees up
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    tenths_inc = tick ? tenths + 4'd1 : tenths;
    pwm        = {4'b0, tenths_inc} <= duty_tenths;
    ms_wrap    = tick && (tenths_inc >= TENTHS_PER_MS);
    millis_inc = millis + MILLIS_W'(1);
  end

  // tenths and millisecond counters
  always_ff @(posedge clk) begin
    if (rst) begin
      tenths <= '0;
      millis <= '0;
    end else if (in_xfer) begin
      if (ms_wrap) begin
        tenths <= tenths_inc - TENTHS_PER_MS;
        millis <= millis_inc;
      end else begin
        tenths <= tenths_inc;
      end
    end
  end

  // pin output register, driven from led state before the recompute
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (initialised) begin
        pin0 <= pwm && led_on[0];
        pin1 <= pwm && led_on[1];
        pin2 <= pwm && led_on[2];
      end else begin
        // boot indicator on the middle pin
        pin0 <= 1'b0;
        pin1 <= pwm;
        pin2 <= 1'b0;
      end
    end
  end

  // sequencer: shift the new millisecond count through the lanes, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer && ms_wrap && initialised) begin
            state   <= ST_CALC;
            bit_cnt <= '0;
          end
        end
        ST_CALC: begin
          bit_cnt <= bit_cnt + CNT_W'(1);
          if (bit_cnt == CNT_W'(MILLIS_W - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      millis_sr <= millis_inc;
    end else if (state == ST_CALC) begin
      millis_sr <= {millis_sr[MILLIS_W-2:0], 1'b0};
    end
  end

  // lane 0 doubles as the 750 ms scroll cycle divider
  always_comb begin
    lane_ctl.clear = in_xfer;
    lane_ctl.step  = (state == ST_CALC);
    lane_ctl.din   = millis_sr[MILLIS_W-1];
    for (int k = 0; k < NUM_LEDS; k++) begin
      lane_div[k] = period_of(led_timing[k]);
    end
    if (scroll_enable) begin
      lane_div[0] = SCROLL_CYCLE_MS;
    end
  end

  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_lane
    lbp_mod_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .divisor (lane_div[g]),
      .rem     (lane_rem[g])
    );
  end

  // led state from the finished remainders
  always_comb begin
    led_on_next = '0;
    if (scroll_enable) begin
      if (lane_rem[0] < SCROLL_STEP_MS) begin
        led_on_next = 3'b001;
      end else if (lane_rem[0] < {SCROLL_STEP_MS[PERIOD_W-2:0], 1'b0}) begin
        led_on_next = 3'b010;
      end else begin
        led_on_next = 3'b100;
      end
    end else begin
      for (int k = 0; k < NUM_LEDS; k++) begin
        if (led_timing[k][HALF_W-1:0] == HALF_W'(0)) begin
          led_on_next[k] = 1'b0;
        end else if (led_timing[k][HALF_W-1:0] == HALF_W'(1)) begin
          led_on_next[k] = 1'b1;
        end else begin
          led_on_next[k] = lane_rem[k] < {1'b0, led_timing[k][HALF_W-1:0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_on <= '0;
    end else if (state == ST_FINISH) begin
      led_on <= led_on_next;
    end
  end

  // tenths never leaves 0..9
  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    tenths < TENTHS_PER_MS)
    else $error("tenths out of range");

  // a millisecond rollover in three-led mode starts the recompute
  a_calc_start: assert property (@(posedge clk) disable iff (rst)
    in_xfer && ms_wrap && initialised |=> state == ST_CALC && bit_cnt == '0)
    else $error("recompute not started");

  // the last dividend bit leads to the led update
  a_calc_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC && bit_cnt == CNT_W'(MILLIS_W - 1) |=> state == ST_FINISH)
    else $error("recompute did not finish");

  // led state changes only at the end of a recompute
  a_led_hold: assert property (@(posedge clk) disable iff (rst)
    $past(state) != ST_FINISH |-> $stable(led_on))
    else $error("led state changed outside recompute");

endmodule

// File: sv/lbp_mod_lane.sv
// ----------------------------------------------------------------------------
// lbp_mod_lane
// bit-serial restoring remainder, one dividend bit per cycle while step is high, msb first
// ----------------------------------------------------------------------------
module lbp_mod_lane import lbp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  lane_ctl_t           ctl,
  input  logic [PERIOD_W-1:0] divisor,
  output logic [PERIOD_W-1:0] rem
);

  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W-1:0] rem_next;

  always_comb begin
    shifted = {rem, ctl.din};
    if (shifted >= {1'b0, divisor}) begin
      rem_next = PERIOD_W'(shifted - {1'b0, divisor});
    end else begin
      rem_next = shifted[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.step) begin
      rem <= rem_next;
    end
  end

  // partial remainder stays below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.step && !ctl.clear && divisor != '0 && rem < divisor |=> rem < $past(divisor))
    else $error("remainder reached divisor");

endmodule

// File: verif/three_led_blink_pwm_controller_top_tb.sv
// ----------------------------------------------------------------------------
// three_led_blink_pwm_controller_top_tb
// self-checking bench for the three-led blink and pwm controller: ticks are
// sent in random bursts while the pin channel stalls on its own pattern; a
// cycle-free model of the tenths, millisecond and led state predicts the
// pin levels of every tick transfer, which are checked in order
// ----------------------------------------------------------------------------
module three_led_blink_pwm_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lbp_pkg::*;

  // extra cycles after the last pin transfer: a millisecond rollover keeps
  // the block busy after its tick transfer while the lanes recompute
  localparam int BUSY_CYCLES = 40;
  // indexes past the register list, written only to see them ignored
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                tick      = 1'b0;
  logic                out_ready = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [2:0]          cfg_index = 3'd0;
  logic [TIMING_W-1:0] cfg_data  = '0;
  logic                in_ready;
  logic                out_valid;
  logic                pin0;
  logic                pin1;
  logic                pin2;
  logic                cfg_ready;

  three_led_blink_pwm_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pin0      (pin0),
    .pin1      (pin1),
    .pin2      (pin2),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow registers, same reset values as the block
  logic [7:0]          duty_r   = 8'd5;
  logic                scroll_r = 1'b0;
  logic                init_r   = 1'b0;
  logic [TIMING_W-1:0] timing_r [NUM_LEDS] = '{default: '0};

  // shadow time base and led states
  logic [3:0]          tenths_q = 4'd0;
  logic [MILLIS_W-1:0] millis_q = '0;
  logic [2:0]          lit_q    = 3'd0;

  // pin levels still owed by the block, bit k is pin k
  logic [2:0] pending_pins [$];

  // sender burst state and receiver hold-off request
  int   burst_left  = 0;
  logic steady_send = 1'b0;
  int   hold_req    = 0;

  // run statistics
  int error_count     = 0;
  int ticks_sent      = 0;
  int idle_ticks      = 0;
  int rollovers       = 0;
  int reg_writes      = 0;
  int pins_checked    = 0;
  int in_stall_cycles = 0;
  int scroll_pos_max  = 0;

  // ---------------------------------------------------------------- model

  // blink rule of one led at the current millisecond
  function automatic logic blink_lit(input logic [TIMING_W-1:0] timing);
    logic [HALF_W-1:0]   on_ms;
    logic [HALF_W-1:0]   off_ms;
    logic [PERIOD_W-1:0] span;
    on_ms  = timing[HALF_W-1:0];
    off_ms = timing[TIMING_W-1:HALF_W];
    if (on_ms == 16'd0) return 1'b0;
    if (on_ms == 16'd1) return 1'b1;
    // 17-bit period so that two full halves never wrap
    if (off_ms == 16'd0) begin
      span = {on_ms, 1'b0};
    end else begin
      span = {1'b0, on_ms} + {1'b0, off_ms};
    end
    return (millis_q % {15'd0, span}) < {16'd0, on_ms};
  endfunction

  function automatic void relight_leds();
    int pos;
    if (scroll_r) begin
      // one lit led, moving on every third of the 750 ms cycle
      pos = int'((millis_q % 32'(SCROLL_CYCLE_MS)) / 32'(SCROLL_STEP_MS));
      lit_q = 3'b001 << pos;
      if (pos > scroll_pos_max) scroll_pos_max = pos;
    end else begin
      for (int k = 0; k < NUM_LEDS; k++) lit_q[k] = blink_lit(timing_r[k]);
    end
  endfunction

  // pin levels of one tick transfer, then the time base moves on
  task automatic step_blinker(input logic t, output logic [2:0] pins);
    logic pwm;
    if (t) tenths_q = tenths_q + 4'd1;
    pwm = ({4'd0, tenths_q} <= duty_r);
    if (init_r) begin
      pins = lit_q & {3{pwm}};
    end else begin
      // boot indicator: middle pin only
      pins = {1'b0, pwm, 1'b0};
    end
    if (t && tenths_q >= TENTHS_PER_MS) begin
      tenths_q = tenths_q - TENTHS_PER_MS;
      millis_q = millis_q + 32'd1;
      rollovers++;
      // led states freeze while the block is not initialised
      if (init_r) relight_leds();
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // one register write transfer; valid stays up for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [TIMING_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DUTY:   duty_r      = data[7:0];
      REG_SCROLL: scroll_r    = data[0];
      REG_INIT:   init_r      = data[0];
      REG_LED0:   timing_r[0] = data;
      REG_LED1:   timing_r[1] = data;
      REG_LED2:   timing_r[2] = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic close_writes();
    cfg_valid <= 1'b0;
  endtask

  // one tick transfer, preceded by a random gap at the start of a burst
  task automatic send_tick(input logic t);
    int         gap;
    logic [2:0] pins;
    gap = 0;
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        case ($urandom_range(0, 3))
          0: gap = 0;
          1: gap = $urandom_range(1, 3);
          2: gap = $urandom_range(1, 12);
          default: gap = $urandom_range(0, 30);
        endcase
      end
      burst_left--;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= t;
    @(posedge clk);
    while (!in_ready) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    step_blinker(t, pins);
    pending_pins.push_back(pins);
    ticks_sent++;
    if (!t) idle_ticks++;
  endtask

  // block idle: every pin transfer in and the rollover work finished
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_pins(input logic [2:0] got);
    logic [2:0] want;
    if (pending_pins.size() == 0) begin
      error_count++;
      if (error_count <= 10) $display("pin transfer with nothing expected: pins %b", got);
      return;
    end
    want = pending_pins.pop_front();
    pins_checked++;
    for (int k = 0; k < NUM_LEDS; k++) begin
      if (got[k] !== want[k]) begin
        error_count++;
        if (error_count <= 10) begin
          $display("pin%0d wrong on transfer %0d: expected %b, got %b",
                   k, pins_checked, want[k], got[k]);
        end
      end
    end
  endtask

  // receiver: checks each pin transfer, then picks out_ready for the next
  // edge from a randomly changing mode, or holds off
  initial begin : pin_receiver
    int mode;
    int mode_left;
    int hold_left;
    int beat;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    beat      = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_pins({pin2, pin1, pin0});
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        beat++;
        case (mode)
          0: out_ready <= 1'b1;                              // no stalls
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= (beat % 3 != 0);                   // fixed rhythm
          default: out_ready <= ($urandom_range(0, 9) < 3);  // mostly stalled
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [7:0] random_duty();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return ($urandom_range(0, 1) != 0) ? 8'd9 : 8'd10;
      3: return 8'($urandom);
      default: return 8'($urandom_range(0, 11));
    endcase
  endfunction

  // mostly short blink timings, since the run covers under two hundred ms
  function automatic logic [TIMING_W-1:0] random_timing();
    logic [HALF_W-1:0] on_ms;
    logic [HALF_W-1:0] off_ms;
    case ($urandom_range(0, 9))
      0: begin
        on_ms  = 16'd0;
        off_ms = 16'($urandom);
      end
      1: begin
        on_ms  = 16'd1;
        off_ms = 16'($urandom);
      end
      2, 3: begin
        on_ms  = 16'($urandom_range(2, 8));
        off_ms = 16'($urandom_range(0, 8));
      end
      4, 5: begin
        on_ms  = 16'($urandom_range(2, 40));
        off_ms = 16'($urandom_range(0, 60));
      end
      6: begin
        // off time zero: period is twice the on time
        on_ms  = 16'($urandom_range(2, 60));
        off_ms = 16'd0;
      end
      7: begin
        on_ms  = 16'hFFFF;
        off_ms = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      end
      8: begin
        on_ms  = 16'($urandom_range(2, 200));
        off_ms = 16'hFFFF;
      end
      default: begin
        on_ms  = 16'($urandom);
        off_ms = 16'($urandom);
      end
    endcase
    return {off_ms, on_ms};
  endfunction

  // boot indicator at reset values, across a millisecond, with an idle tick
  task automatic test_boot_indicator();
    for (int i = 0; i < 12; i++) send_tick(i != 4);
  endtask

  // register extremes: duty 0 and 255, the three led special timings,
  // upper data bits of one-bit registers and writes past the register list
  task automatic test_register_extremes();
    wait_idle();
    write_reg(REG_SPARE6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE7, 32'hFFFF_FFFF);
    write_reg(REG_DUTY,   32'hFFFF_FF00);
    write_reg(REG_SCROLL, 32'hFFFF_FFFE);
    write_reg(REG_INIT,   32'h8000_0001);
    write_reg(REG_LED0,   32'hFFFF_0000);   // on time zero: dark
    write_reg(REG_LED1,   32'h0000_0001);   // on time one: always lit
    write_reg(REG_LED2,   32'hFFFF_FFFF);   // largest period
    close_writes();
    for (int i = 0; i < 11; i++) send_tick(1'b1);
    wait_idle();
    write_reg(REG_DUTY, 32'h0000_00FF);
    close_writes();
    for (int i = 0; i < 2; i++) send_tick(1'b1);
  endtask

  // phases of random settings, each followed by a run of random ticks
  task automatic test_random_blink();
    int items;
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      if (p == 0 || $urandom_range(0, 2) != 0) write_reg(REG_DUTY, {24'($urandom), random_duty()});
      if (p == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(REG_SCROLL, {31'($urandom), 1'($urandom_range(0, 3) == 0)});
      end
      if (p == 0 || $urandom_range(0, 2) != 0) begin
        write_reg(REG_INIT, {31'($urandom), 1'($urandom_range(0, 6) != 0)});
      end
      if (p == 0 || $urandom_range(0, 1) != 0) write_reg(REG_LED0, random_timing());
      if (p == 0 || $urandom_range(0, 1) != 0) write_reg(REG_LED1, random_timing());
      if (p == 0 || $urandom_range(0, 1) != 0) write_reg(REG_LED2, random_timing());
      close_writes();
      items = $urandom_range(80, 130);
      for (int i = 0; i < items; i++) send_tick($urandom_range(0, 9) != 0);
    end
  endtask

  // long receiver hold-off against a sender with no gaps: the block fills
  // and must stall its tick input without losing or repeating a transfer
  task automatic test_output_backpressure();
    wait_idle();
    hold_req    = 300;
    steady_send = 1'b1;
    for (int i = 0; i < 60; i++) send_tick(1'b1);
    steady_send = 1'b0;
  endtask

  // scroll mode with its own duty; the run stays inside the first 250 ms,
  // so the first led of the rotation is the lit one
  task automatic test_scroll_rotation();
    wait_idle();
    write_reg(REG_SCROLL, 32'h0000_0001);
    write_reg(REG_INIT,   32'h0000_0001);
    write_reg(REG_DUTY,   {24'd0, 8'($urandom_range(0, 11))});
    close_writes();
    for (int i = 0; i < 400; i++) send_tick($urandom_range(0, 15) != 0);
  endtask

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_boot_indicator();
    test_register_extremes();
    test_random_blink();
    test_output_backpressure();
    test_scroll_rotation();

    // let the last transfers drain, bounded, then give the block time to
    // show any pin transfer it should not make
    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && pending_pins.size() != 0; w++) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
    if (pending_pins.size() != 0) begin
      error_count += pending_pins.size();
      $display("%0d expected pin transfers never arrived", pending_pins.size());
    end

    $display("sent %0d ticks (%0d with no time step), %0d ms rollovers, %0d register writes",
             ticks_sent, idle_ticks, rollovers, reg_writes);
    $display("checked %0d pin transfers, tick input stalled %0d cycles, scroll reached led %0d",
             pins_checked, in_stall_cycles, scroll_pos_max);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin : watchdog
    #(64'd30_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
sv/lbp_pkg.sv
sv/lbp_mod_lane.sv
sv/three_led_blink_pwm_controller_top.sv
verif/three_led_blink_pwm_controller_top_tb.sv
